[design/assert_macros.svh]
// Assertion helpers used by the page table walk module.
// Each macro samples on the rising edge of clock and is switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pgw_pkg.sv]
package pgw_pkg;

   // Fixed field widths and bit positions of the walk.
   localparam int PGW_PHYS_WORDS = 65536;
   localparam int INDEX_BITS     = 9;
   localparam int WORD_W         = 64;
   localparam int PADDR_W        = 52;
   localparam int LA_W           = 48;
   localparam int WIDX_W         = 16;
   localparam int STATUS_W       = 3;
   localparam int ENTRY_BASE_LSB = 12;
   localparam int ENTRY_BASE_MSB = 51;
   localparam int LEVELS         = 4;
   localparam int LEVEL_W        = 2;
   localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(LEVELS - 1);

   // Register file: one 64-bit register, index taken from paddr bit 3.
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_LSB = 3;
   localparam logic REG_ROOT_TABLE_BASE = 1'b0;

   // Request kinds carried in tuser.
   localparam logic ACTION_WALK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_NO_ROOT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALL_PRESENT = 3'd5;
   localparam logic [STATUS_W-1:0] ST_WRITE_DONE  = 3'd6;

   // Microprogram step addresses.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CLEAR    = 3'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ADDR     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CHECK    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DONE     = 3'd5;

   // Jump condition selectors.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd0;
   localparam logic [COND_W-1:0] COND_REQ_TAKEN  = 3'd1;
   localparam logic [COND_W-1:0] COND_IS_WALK    = 3'd2;
   localparam logic [COND_W-1:0] COND_WALK_END   = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_FREE   = 3'd4;
   localparam logic [COND_W-1:0] COND_CLEAR_LAST = 3'd5;

   // One control word of the microprogram.
   typedef struct packed {
      logic              req_ready;
      logic              rd_entry;
      logic              chk_entry;
      logic              ld_out;
      logic              clr_mem;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] tgt_true;
      logic [STEP_W-1:0] tgt_false;
   } ctrl_word_type;

   // Datapath flags tested by the jump conditions.
   typedef struct packed {
      logic req_taken;
      logic is_walk;
      logic walk_end;
      logic out_free;
      logic clear_last;
   } cond_flags_type;

   // Control store, one word per step.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         STEP_CLEAR: begin
            w.clr_mem   = 1'b1;
            w.cond      = COND_CLEAR_LAST;
            w.tgt_true  = STEP_IDLE;
            w.tgt_false = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.req_ready = 1'b1;
            w.cond      = COND_REQ_TAKEN;
            w.tgt_true  = STEP_DISPATCH;
            w.tgt_false = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.cond      = COND_IS_WALK;
            w.tgt_true  = STEP_ADDR;
            w.tgt_false = STEP_DONE;
         end
         STEP_ADDR: begin
            w.rd_entry  = 1'b1;
            w.cond      = COND_ALWAYS;
            w.tgt_true  = STEP_CHECK;
            w.tgt_false = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.chk_entry = 1'b1;
            w.cond      = COND_WALK_END;
            w.tgt_true  = STEP_DONE;
            w.tgt_false = STEP_ADDR;
         end
         STEP_DONE: begin
            w.ld_out    = 1'b1;
            w.cond      = COND_OUT_FREE;
            w.tgt_true  = STEP_IDLE;
            w.tgt_false = STEP_DONE;
         end
         default: begin
            w.cond      = COND_ALWAYS;
            w.tgt_true  = STEP_IDLE;
            w.tgt_false = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[design/four_level_page_table_walk.sv]
// Channel   Direction  Handshake                    Contents
// req_      in         tvalid / tready              lookup or table word write
// rsp_      out        tvalid / tready              status, deepest entry and base
// csr_      in         psel / penable / pready      root_table_base at byte address 0
//
// A write item, or a lookup with no root table, goes from dispatch straight to the final
// step; a lookup passes through an address step and a check step for each table level
// read, and the sequencer returns to its idle step before the next request transfer.
// Each level is one registered memory read and one entry check, run by the microprogram
// in series. After reset a clearing pass writes zero to every table word, with req_tready
// low. The next request is taken while a result still waits in the output register; a
// stalled result holds the sequencer in its final step.
`include "assert_macros.svh"

module four_level_page_table_walk import pgw_pkg::*; #(
   parameter int PHYS_WORDS = PGW_PHYS_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // lookup_addr [47:0], word_index [63:48], word_data [127:64]
   input  logic [127:0]          req_tdata,
   // action [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // deepest_entry_addr [51:0], child_base [103:52]
   output logic [103:0]          rsp_tdata,
   // status [2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(PHYS_WORDS);

   ctrl_word_type     ctrl;
   cond_flags_type    flags;
   logic [STEP_W-1:0] step;

   logic [PADDR_W-1:0]  root_base_ff, root_base_in;
   logic                action_ff, action_in;
   logic [LA_W-1:0]     la_ff, la_in;
   logic [PADDR_W-1:0]  base_ff, base_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [PADDR_W-1:0]  entry_addr_ff, entry_addr_in;
   logic [PADDR_W-1:0]  deep_addr_ff, deep_addr_in;
   logic [PADDR_W-1:0]  deep_base_ff, deep_base_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [PADDR_W-1:0]  rsp_base_ff, rsp_base_in;

   logic                req_taken;
   logic                csr_write;
   logic                out_free;
   logic                entry_zero;
   logic [INDEX_BITS-1:0] level_idx;
   logic [PADDR_W-1:0]  next_entry_addr;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [WORD_W-1:0]   mem_wr_data;
   logic [WORD_W-1:0]   mem_rd_data;

   // Microprogram sequencer.
   pgw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .step  (step)
   );

   // Table memory.
   pgw_table_mem #(
      .PHYS_WORDS (PHYS_WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (ctrl.rd_entry),
      .rd_addr (next_entry_addr[ADDR_W+2:3]),
      .rd_data (mem_rd_data)
   );

   // Handshakes.
   assign req_tready = ctrl.req_ready;
   assign req_taken  = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register read-back.
   assign csr_prdata = (csr_paddr[CSR_INDEX_LSB] == REG_ROOT_TABLE_BASE)
                       ? CSR_DATA_W'(root_base_ff) : '0;

   // Index of the current level, root level in the highest bits.
   always_comb begin
      case (level_ff)
         2'd0:    level_idx = la_ff[ENTRY_BASE_LSB + 3*INDEX_BITS +: INDEX_BITS];
         2'd1:    level_idx = la_ff[ENTRY_BASE_LSB + 2*INDEX_BITS +: INDEX_BITS];
         2'd2:    level_idx = la_ff[ENTRY_BASE_LSB + INDEX_BITS +: INDEX_BITS];
         default: level_idx = la_ff[ENTRY_BASE_LSB +: INDEX_BITS];
      endcase
   end

   assign next_entry_addr = base_ff + PADDR_W'({level_idx, 3'b000});
   assign entry_zero      = (mem_rd_data == '0);

   // Flags for the jump conditions.
   assign flags.req_taken  = req_taken;
   assign flags.is_walk    = (action_ff == ACTION_WALK) && (base_ff != '0);
   assign flags.walk_end   = entry_zero || (level_ff == LEVEL_LAST);
   assign flags.out_free   = out_free;
   assign flags.clear_last = &clear_cnt_ff;

   // Memory writes come from the clearing pass or from a write transfer.
   assign mem_wr_en   = ctrl.clr_mem | (req_taken & (req_tuser == ACTION_WRITE));
   assign mem_wr_addr = ctrl.clr_mem ? clear_cnt_ff : ADDR_W'(req_tdata[LA_W +: WIDX_W]);
   assign mem_wr_data = ctrl.clr_mem ? '0 : req_tdata[LA_W + WIDX_W +: WORD_W];

   // Datapath next values, steered by the control word.
   always_comb begin
      root_base_in  = root_base_ff;
      action_in     = action_ff;
      la_in         = la_ff;
      base_in       = base_ff;
      level_in      = level_ff;
      entry_addr_in = entry_addr_ff;
      deep_addr_in  = deep_addr_ff;
      deep_base_in  = deep_base_ff;
      status_in     = status_ff;
      clear_cnt_in  = clear_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_base_in   = rsp_base_ff;

      if (csr_write && (csr_paddr[CSR_INDEX_LSB] == REG_ROOT_TABLE_BASE)) begin
         root_base_in = csr_pwdata[PADDR_W-1:0];
      end

      if (ctrl.clr_mem) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
      end

      // A new item starts with an empty result.
      if (req_taken) begin
         action_in    = req_tuser;
         la_in        = req_tdata[LA_W-1:0];
         base_in      = root_base_ff;
         level_in     = '0;
         deep_addr_in = '0;
         deep_base_in = '0;
         status_in    = (req_tuser == ACTION_WRITE) ? ST_WRITE_DONE : ST_NO_ROOT;
      end

      if (ctrl.rd_entry) begin
         entry_addr_in = next_entry_addr;
      end

      // A zero entry ends the walk; a present one becomes the next base.
      if (ctrl.chk_entry) begin
         if (entry_zero) begin
            status_in = STATUS_W'(level_ff) + 3'd1;
         end else begin
            deep_addr_in = entry_addr_ff;
            deep_base_in = {mem_rd_data[ENTRY_BASE_MSB:ENTRY_BASE_LSB],
                            {ENTRY_BASE_LSB{1'b0}}};
            base_in      = {mem_rd_data[ENTRY_BASE_MSB:ENTRY_BASE_LSB],
                            {ENTRY_BASE_LSB{1'b0}}};
            level_in     = level_ff + 1'b1;
            if (level_ff == LEVEL_LAST) begin
               status_in = ST_ALL_PRESENT;
            end
         end
      end

      // Output register: emptied by a transfer, loaded when the item is done.
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.ld_out && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_addr_in   = deep_addr_ff;
         rsp_base_in   = deep_base_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_base_ff <= '0;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_base_ff <= root_base_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      la_ff         <= la_in;
      base_ff       <= base_in;
      level_ff      <= level_in;
      entry_addr_ff <= entry_addr_in;
      deep_addr_ff  <= deep_addr_in;
      deep_base_ff  <= deep_base_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_base_ff   <= rsp_base_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_base_ff, rsp_addr_ff};

   // Sequencer checks.
   `PGW_ASSERT_NEXT(a_accept_dispatch, req_taken, step == STEP_DISPATCH, "no dispatch after transfer")
   `PGW_ASSERT_SAME(a_check_after_read, step == STEP_CHECK, $past(step) == STEP_ADDR, "check without read")
   `PGW_ASSERT_NEXT(a_done_loads_out, (step == STEP_DONE) && out_free, rsp_tvalid, "result not loaded")
   `PGW_ASSERT_SAME(a_no_req_in_clear, step == STEP_CLEAR, !req_tready, "request taken while clearing")

endmodule

[design/pgw_table_mem.sv]
module pgw_table_mem import pgw_pkg::*; #(
   parameter int PHYS_WORDS = PGW_PHYS_WORDS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(PHYS_WORDS)-1:0] wr_addr,
   input  logic [WORD_W-1:0]             wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(PHYS_WORDS)-1:0] rd_addr,
   output logic [WORD_W-1:0]             rd_data
);

   logic [WORD_W-1:0] mem_ff [PHYS_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pgw_seq.sv]
module pgw_seq import pgw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cond_flags_type    flags,
   output ctrl_word_type     ctrl,
   output logic [STEP_W-1:0] step
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              cond_hit;

   // Fetch the control word of the current step.
   assign ctrl = ucode_rom(step_ff);

   // Evaluate the selected jump condition.
   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:     cond_hit = 1'b1;
         COND_REQ_TAKEN:  cond_hit = flags.req_taken;
         COND_IS_WALK:    cond_hit = flags.is_walk;
         COND_WALK_END:   cond_hit = flags.walk_end;
         COND_OUT_FREE:   cond_hit = flags.out_free;
         COND_CLEAR_LAST: cond_hit = flags.clear_last;
         default:         cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? ctrl.tgt_true : ctrl.tgt_false;
   end

   // The step counter starts with the memory clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

[tb/sv/four_level_page_table_walk_tb.sv]
`timescale 1ns / 100ps

module four_level_page_table_walk_tb;
   import pgw_pkg::*;

   // Missing-entry status codes: one per table level, counted from the root.
   localparam logic [STATUS_W-1:0] ST_MISSING_L1 = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING_L2 = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING_L3 = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISSING_L4 = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] ROOT_BASE_ADDR =
      CSR_ADDR_W'(REG_ROOT_TABLE_BASE) << CSR_INDEX_LSB;
   localparam logic [PADDR_W-1:0] ROOT_BASE_MAX = {PADDR_W{1'b1}};

   localparam int DRAIN_CYCLES         = 16;
   localparam int ITEMS_PER_ROOT_BASE  = 90;
   localparam int TIMEOUT_NS           = 5_000_000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PADDR_W-1:0]  entry_addr;
      logic [PADDR_W-1:0]  child_base;
   } walk_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [127:0]          req_tdata;   // lookup_addr [47:0], word_index [63:48], word_data [127:64]
   logic                  req_tuser;   // action [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [103:0]          rsp_tdata;   // deepest_entry_addr [51:0], child_base [103:52]
   logic [STATUS_W-1:0]   rsp_tuser;   // status [2:0]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the block's state, kept in transfer order.
   logic [WORD_W-1:0]  table_copy [PGW_PHYS_WORDS];
   logic [PADDR_W-1:0] root_base_copy;
   walk_result_type    walk_results [$];

   int error_count    = 0;
   int items_sent     = 0;
   int root_settings  = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int status_count [8];

   four_level_page_table_walk u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut short if the block stops making progress.
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   // Result side back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Word index that a byte address falls on, with aliasing over the memory size.
   function automatic int word_of(input logic [PADDR_W-1:0] byte_addr);
      return int'((byte_addr >> 3) % PGW_PHYS_WORDS);
   endfunction

   // Byte address of the entry for one level; level 0 is the root table.
   function automatic logic [PADDR_W-1:0] entry_byte_addr(input logic [PADDR_W-1:0] base,
                                                           input logic [LA_W-1:0] la,
                                                           input int lvl);
      logic [INDEX_BITS-1:0] idx;
      idx = INDEX_BITS'(la >> (ENTRY_BASE_LSB + INDEX_BITS * (LEVELS - 1 - lvl)));
      return PADDR_W'(base + (PADDR_W'(idx) << 3));
   endfunction

   function automatic logic [PADDR_W-1:0] child_base_of(input logic [WORD_W-1:0] entry);
      return {entry[ENTRY_BASE_MSB:ENTRY_BASE_LSB], {ENTRY_BASE_LSB{1'b0}}};
   endfunction

   // Expected outcome of a lookup against the shadow table and root base.
   function automatic walk_result_type predict_walk(input logic [LA_W-1:0] la);
      walk_result_type    r;
      logic [PADDR_W-1:0] base;
      logic [PADDR_W-1:0] addr;
      logic [WORD_W-1:0]  entry;
      int                 lvl;
      logic               stopped;
      r = '0;
      r.status = ST_ALL_PRESENT;
      base = root_base_copy;
      stopped = 1'b0;
      if (base == '0) begin
         r.status = ST_NO_ROOT;
         stopped = 1'b1;
      end
      lvl = 0;
      while (!stopped && lvl < LEVELS) begin
         addr = entry_byte_addr(base, la, lvl);
         entry = table_copy[word_of(addr)];
         if (entry == '0) begin
            // Missing codes follow on from level 1 in order.
            r.status = ST_MISSING_L1 + STATUS_W'(lvl);
            stopped = 1'b1;
         end else begin
            r.entry_addr = addr;
            r.child_base = child_base_of(entry);
            base = r.child_base;
         end
         lvl++;
      end
      return r;
   endfunction

   // Word that the walk of la reads at the given level, following the shadow table.
   function automatic int entry_word_at(input logic [LA_W-1:0] la, input int depth);
      logic [PADDR_W-1:0] base;
      int                 w;
      int                 lvl;
      base = root_base_copy;
      w = 0;
      for (lvl = 0; lvl <= depth; lvl++) begin
         w = word_of(entry_byte_addr(base, la, lvl));
         base = child_base_of(table_copy[w]);
      end
      return w;
   endfunction

   function automatic logic [PADDR_W-1:0] random_root_base();
      logic [PADDR_W-1:0] r;
      r = PADDR_W'({$urandom, $urandom});
      if ($urandom_range(1) == 1)
         r = PADDR_W'($urandom_range(1, PGW_PHYS_WORDS - 1)) << 3;
      return r;
   endfunction

   // Send one request and record its expected result once the transfer happens.
   task automatic send_item(input logic act, input logic [LA_W-1:0] la,
                            input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
      walk_result_type exp;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {wdata, widx, la};
      do @(posedge clock); while (!req_tready);
      if (act == ACTION_WRITE) begin
         table_copy[widx] = wdata;
         exp = '0;
         exp.status = ST_WRITE_DONE;
      end else begin
         exp = predict_walk(la);
      end
      walk_results.push_back(exp);
      items_sent++;
   endtask

   // Fields that the block ignores for an action carry random values.
   task automatic write_word(input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
      send_item(ACTION_WRITE, LA_W'({$urandom, $urandom}), widx, wdata);
   endtask

   task automatic lookup(input logic [LA_W-1:0] la);
      send_item(ACTION_WALK, la, WIDX_W'($urandom), {$urandom, $urandom});
   endtask

   // Hold the request side idle until every outstanding result has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (walk_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the root base, then read it back in the next transfer.
   task automatic set_root_base(input logic [PADDR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROOT_BASE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      root_base_copy = value;
      root_settings++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $display("%0t: root base read back: expected %h, actual %h",
                  $realtime, CSR_DATA_W'(value), csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Lookups with no root table, before and after the memory holds data.
   task automatic test_no_root();
      lookup('0);
      lookup({LA_W{1'b1}});
      write_word('0, {WORD_W{1'b1}});
      write_word({WIDX_W{1'b1}}, 64'h8000_0000_0000_0001);
      lookup('0);
   endtask

   // Build one walk a level at a time so that each missing level is seen.
   task automatic test_walk_levels();
      logic [LA_W-1:0] la;
      la = 48'hA5A5_5A5A_3C3C;
      wait_for_results();
      set_root_base(52'h0_0000_0000_1000);
      lookup(la);
      // Bits above 51 and below 12 must not reach the next base.
      write_word(WIDX_W'(entry_word_at(la, 0)), 64'hFFF0_0000_0003_0FFF);
      lookup(la);
      // A present entry may still point at a base of zero.
      write_word(WIDX_W'(entry_word_at(la, 1)), 64'h0000_0000_0000_0001);
      lookup(la);
      write_word(WIDX_W'(entry_word_at(la, 2)), 64'h000F_FFFF_FFFF_F000);
      lookup(la);
      write_word(WIDX_W'(entry_word_at(la, 3)), {WORD_W{1'b1}});
      lookup(la);
      lookup(la | LA_W'(12'hFFF));
      write_word(WIDX_W'(entry_word_at(la, 3)), '0);
      lookup(la);
   endtask

   // Root entry address wrapping at 52 bits, and a root base that is not word aligned.
   task automatic test_root_extremes();
      logic [LA_W-1:0] la;
      la = 48'hFF80_0000_0000;
      wait_for_results();
      set_root_base(ROOT_BASE_MAX);
      write_word(WIDX_W'(entry_word_at(la, 0)), 64'h0000_0000_0004_2000);
      lookup(la);
      wait_for_results();
      set_root_base(52'h0_0000_0002_0005);
      write_word(WIDX_W'(entry_word_at('0, 0)), 64'h0000_0000_0006_1000);
      lookup('0);
      lookup({LA_W{1'b1}});
   endtask

   // One well-formed table chain with random content, then lookups that use it.
   task automatic build_and_walk();
      logic [LA_W-1:0]   la;
      logic [LA_W-1:0]   probe;
      logic [WORD_W-1:0] data;
      int                depth;
      int                lvl;
      int                w;
      la = LA_W'({$urandom, $urandom});
      depth = ($urandom_range(99) < 50) ? LEVELS : $urandom_range(0, LEVELS - 1);
      for (lvl = 0; lvl < depth; lvl++) begin
         w = entry_word_at(la, lvl);
         if (table_copy[w] == '0 || $urandom_range(3) == 0) begin
            data = {$urandom, $urandom};
            if (data == '0)
               data = 64'h1;
            write_word(WIDX_W'(w), data);
         end
      end
      // Sometimes clear the entry one level below the chain so the walk stops there.
      if (depth < LEVELS && $urandom_range(1) == 1)
         write_word(WIDX_W'(entry_word_at(la, depth)), '0);
      repeat ($urandom_range(1, 3)) begin
         probe = la;
         if ($urandom_range(2) == 1)
            probe[ENTRY_BASE_LSB-1:0] = ENTRY_BASE_LSB'($urandom);
         else if ($urandom_range(1) == 1)
            probe[ENTRY_BASE_LSB+INDEX_BITS-1:0] = (ENTRY_BASE_LSB + INDEX_BITS)'($urandom);
         lookup(probe);
      end
   endtask

   // Stray writes, some clearing entries, and lookups of unrelated addresses.
   task automatic table_noise();
      if ($urandom_range(1) == 1)
         write_word(WIDX_W'($urandom),
                    ($urandom_range(3) == 0) ? '0 : {$urandom, $urandom});
      else
         lookup(LA_W'({$urandom, $urandom}));
   endtask

   // One idling phase: a random root base, then an extreme one.
   task automatic test_random_walks(input int send_pct, input int stall,
                                    input logic [PADDR_W-1:0] extreme_root);
      int settings;
      int start;
      send_idle_pct = send_pct;
      stall_pct     = stall;
      for (settings = 0; settings < 2; settings++) begin
         wait_for_results();
         if (settings == 0)
            set_root_base(random_root_base());
         else
            set_root_base(extreme_root);
         start = items_sent;
         while (items_sent - start < ITEMS_PER_ROOT_BASE) begin
            if ($urandom_range(9) < 8)
               build_and_walk();
            else
               table_noise();
         end
      end
   endtask

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      walk_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (walk_results.size() == 0) begin
            $display("%0t: result with no request waiting: status %0d, addr %h, base %h",
                     $realtime, rsp_tuser, rsp_tdata[51:0], rsp_tdata[103:52]);
            error_count++;
         end else begin
            exp = walk_results.pop_front();
            status_count[exp.status]++;
            if (rsp_tuser !== exp.status) begin
               $display("%0t: status: expected %0d, actual %0d",
                        $realtime, exp.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[51:0] !== exp.entry_addr) begin
               $display("%0t: deepest entry address: expected %h, actual %h",
                        $realtime, exp.entry_addr, rsp_tdata[51:0]);
               error_count++;
            end
            if (rsp_tdata[103:52] !== exp.child_base) begin
               $display("%0t: deepest base: expected %h, actual %h",
                        $realtime, exp.child_base, rsp_tdata[103:52]);
               error_count++;
            end
         end
      end
   end

   // Reset, directed tests, random phases and the final check.
   initial begin
      foreach (table_copy[i]) table_copy[i] = '0;
      foreach (status_count[i]) status_count[i] = 0;
      root_base_copy = '0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= ACTION_WALK;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_no_root();
      test_walk_levels();
      test_root_extremes();
      test_random_walks(0, 0, ROOT_BASE_MAX);
      test_random_walks(56, 0, 52'hF_FFFF_FFFF_F000);
      test_random_walks(0, 56, 52'h0_0000_0000_0008);
      test_random_walks(30, 30, '0);

      wait_for_results();
      $display("Covered %0d lookups: no root %0d, missing at levels 1 to 4: %0d %0d %0d %0d,",
               status_count[ST_NO_ROOT] + status_count[ST_MISSING_L1]
               + status_count[ST_MISSING_L2] + status_count[ST_MISSING_L3]
               + status_count[ST_MISSING_L4] + status_count[ST_ALL_PRESENT],
               status_count[ST_NO_ROOT], status_count[ST_MISSING_L1],
               status_count[ST_MISSING_L2], status_count[ST_MISSING_L3],
               status_count[ST_MISSING_L4]);
      $display("complete walks %0d, table writes %0d, root base settings %0d, errors %0d",
               status_count[ST_ALL_PRESENT], status_count[ST_WRITE_DONE],
               root_settings, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
